### hw/rtl/pcf_pkg.sv
// Shared codes, constants, types and helper functions of the PCM/float converter.
`timescale 1ns / 1ps

package pcf_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  // Sample formats
  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S24 = 2'd2;
  localparam logic [1:0] FMT_S32 = 2'd3;
  localparam logic [1:0] FMT_RESET = FMT_S16;

  // Directions
  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FMT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BE  = 1'b1;

  // Full scales (all of the form 2^n - 1)
  localparam logic [30:0] FS_U8  = 31'd127;
  localparam logic [30:0] FS_S16 = 31'd32767;
  localparam logic [30:0] FS_S24 = 31'd8388607;
  localparam logic [30:0] FS_S32 = 31'h7fff_ffff;

  // Saturation words
  localparam logic [7:0]  U8_MAX  = 8'd255;
  localparam logic [7:0]  U8_MIN  = 8'd0;
  localparam logic [7:0]  U8_OFS  = 8'd128;
  localparam logic [15:0] S16_MAX = 16'h7fff;
  localparam logic [15:0] S16_MIN = 16'h8000;
  localparam logic [23:0] S24_MAX = 24'h7f_ffff;
  localparam logic [23:0] S24_MIN = 24'h80_0001;
  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // Stage load strobes from the pipeline control
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  function automatic logic [30:0] full_scale(input logic [1:0] fmt);
    logic [30:0] fs;
    unique case (fmt)
      FMT_U8:  fs = FS_U8;
      FMT_S16: fs = FS_S16;
      FMT_S24: fs = FS_S24;
      default: fs = FS_S32;
    endcase
    return fs;
  endfunction

  // Bit count n of the full scale 2^n - 1
  function automatic logic [4:0] fmt_bits(input logic [1:0] fmt);
    logic [4:0] n;
    unique case (fmt)
      FMT_U8:  n = 5'd7;
      FMT_S16: n = 5'd15;
      FMT_S24: n = 5'd23;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  // Index of the highest set bit, zero for a zero word
  function automatic logic [4:0] msb31(input logic [30:0] x);
    logic [4:0] m;
    m = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (x[i]) m = 5'(i);
    end
    return m;
  endfunction

endpackage

### hw/rtl/pcf_ifs.sv
// Valid/ready channel interfaces of the PCM/float converter.
`timescale 1ns / 1ps

interface pcf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [pcf_pkg::SAMPLE_W-1:0] sample_in;
  modport source (output valid, output op, output sample_in, input ready);
  modport sink   (input valid, input op, input sample_in, output ready);
endinterface

interface pcf_out_if;
  logic                         valid;
  logic                         ready;
  logic [pcf_pkg::SAMPLE_W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface pcf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pcf_pkg::CFG_IDX_W-1:0]  index;
  logic [pcf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/pcf_encode.sv
// Float32 to PCM datapath: multiply, align, round-and-truncate, saturate and pack.
`timescale 1ns / 1ps

module pcf_encode (
  input  logic                         clk,
  input  pcf_pkg::pipe_en_t            en,
  input  logic [pcf_pkg::SAMPLE_W-1:0] s1_sample,
  input  logic [1:0]                   s1_fmt,
  input  logic                         s1_be,
  output logic [pcf_pkg::SAMPLE_W-1:0] enc_word
);
  import pcf_pkg::*;

  // Stage 2: classify and multiply
  logic [7:0]  ue;
  logic [22:0] mant;
  logic [23:0] mfull;
  logic [7:0]  ue_eff;
  logic [54:0] p_nxt;
  logic [6:0]  rsh_nxt;
  logic        nan_nxt, ovr_nxt;

  logic [54:0] p2_r;
  logic [6:0]  rsh2_r;
  logic        sgn2_r, nan2_r, ovr2_r, be2_r;
  logic [1:0]  fmt2_r;

  always_comb begin
    ue      = s1_sample[30:23];
    mant    = s1_sample[22:0];
    mfull   = {(ue != 8'd0), mant};
    ue_eff  = (ue == 8'd0) ? 8'd1 : ue;
    nan_nxt = (ue == 8'hff) && (mant != 23'd0);
    ovr_nxt = (ue > 8'd127) || ((ue == 8'd127) && (mant != 23'd0));
    rsh_nxt = 7'(8'd127 - ue_eff);
    p_nxt   = {31'd0, mfull} * {24'd0, full_scale(s1_fmt)};
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p2_r   <= p_nxt;
      rsh2_r <= rsh_nxt;
      sgn2_r <= s1_sample[31];
      nan2_r <= nan_nxt;
      ovr2_r <= ovr_nxt;
      fmt2_r <= s1_fmt;
      be2_r  <= s1_be;
    end
  end

  // Stage 3: align to 56 fraction bits, collect the sticky bit
  logic [87:0] wide, shifted, lost_mask;
  logic        st_nxt;

  logic [30:0] ip3_r;
  logic [55:0] fr3_r;
  logic        st3_r, sgn3_r, nan3_r, ovr3_r, be3_r;
  logic [1:0]  fmt3_r;

  always_comb begin
    wide      = {p2_r, 33'd0};
    shifted   = wide >> rsh2_r;
    lost_mask = (rsh2_r >= 7'd88) ? '1 : ((88'd1 << rsh2_r) - 88'd1);
    st_nxt    = |(wide & lost_mask);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      ip3_r  <= shifted[86:56];
      fr3_r  <= shifted[55:0];
      st3_r  <= st_nxt;
      sgn3_r <= sgn2_r;
      nan3_r <= nan2_r;
      ovr3_r <= ovr2_r;
      fmt3_r <= fmt2_r;
      be3_r  <= be2_r;
    end
  end

  // Stage 4: apply the double-precision rounding step, then truncate, saturate and pack
  logic        ip_nz, up_s, up46, gt, fr_any;
  logic [4:0]  ms, ed;
  logic [5:0]  hi_sh;
  logic [55:0] hi_mask, thr;
  logic [30:0] mag;
  logic [31:0] sval;
  logic [6:0]  ip7, d7;
  logic [7:0]  u8_pos, u8_neg, u8_byte;
  logic [15:0] v16;
  logic [31:0] word_nxt;
  logic [31:0] word4_r;

  always_comb begin
    ip_nz   = |ip3_r;
    ms      = msb31(ip3_r);
    hi_sh   = ip_nz ? (6'(ms) + 6'd3) : 6'd2;
    hi_mask = ~((56'd1 << hi_sh) - 56'd1);
    up_s    = (fr3_r & hi_mask) == hi_mask;
    mag     = ip3_r + 31'(up_s);
    sval    = sgn3_r ? (32'd0 - {1'b0, mag}) : {1'b0, mag};

    ip7     = ip3_r[6:0];
    up46    = &fr3_r[55:10];
    u8_pos  = U8_OFS + {1'b0, ip7} + 8'(up46);
    d7      = 7'd127 - ip7;
    ed      = msb31({24'd0, d7});
    thr     = 56'd1 << (6'(ed) + 6'd3);
    gt      = (fr3_r > thr) || ((fr3_r == thr) && st3_r);
    fr_any  = (|fr3_r) || st3_r;
    u8_neg  = (fr_any && gt) ? (8'd127 - {1'b0, ip7}) : (U8_OFS - {1'b0, ip7});
    u8_byte = ovr3_r ? (sgn3_r ? U8_MIN : U8_MAX) : (sgn3_r ? u8_neg : u8_pos);

    v16     = ovr3_r ? (sgn3_r ? S16_MIN : S16_MAX) : sval[15:0];

    unique case (fmt3_r)
      FMT_U8:  word_nxt = {24'd0, u8_byte};
      FMT_S16: word_nxt = be3_r ? {16'd0, v16[7:0], v16[15:8]} : {16'd0, v16};
      FMT_S24: word_nxt = {8'd0, ovr3_r ? (sgn3_r ? S24_MIN : S24_MAX) : sval[23:0]};
      default: word_nxt = ovr3_r ? (sgn3_r ? S32_MIN : S32_MAX) : sval;
    endcase
    if (nan3_r) word_nxt = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      word4_r <= word_nxt;
    end
  end

  assign enc_word = word4_r;

endmodule

### hw/rtl/pcf_decode.sv
// PCM to float32 datapath: expand the quotient, normalize, round twice and pack.
`timescale 1ns / 1ps

module pcf_decode (
  input  logic                         clk,
  input  pcf_pkg::pipe_en_t            en,
  input  logic [pcf_pkg::SAMPLE_W-1:0] s1_sample,
  input  logic [1:0]                   s1_fmt,
  input  logic                         s1_be,
  output logic [pcf_pkg::SAMPLE_W-1:0] dec_word
);
  import pcf_pkg::*;

  // Stage 2: signed value, magnitude, periodic quotient bits, leading-zero count
  logic [15:0]  w16;
  logic [32:0]  sx, av;
  logic         neg_nxt, zero_nxt, ex1, ovr;
  logic [31:0]  a;
  logic [4:0]   n;
  logic [30:0]  u;
  logic [97:0]  rep8;
  logic [104:0] rep16;
  logic [114:0] rep24;
  logic [123:0] rep32;
  logic [95:0]  bfr;
  logic [96:0]  s_nxt;
  logic [5:0]   lz_nxt;

  logic [96:0]  s2_r;
  logic [5:0]   lz2_r;
  logic         neg2_r, zero2_r, ex2_r;

  always_comb begin
    w16 = s1_be ? {s1_sample[7:0], s1_sample[15:8]} : s1_sample[15:0];
    unique case (s1_fmt)
      FMT_U8:  sx = {25'd0, s1_sample[7:0]} - 33'd127;
      FMT_S16: sx = {{17{w16[15]}}, w16};
      FMT_S24: sx = {{9{s1_sample[23]}}, s1_sample[23:0]};
      default: sx = {s1_sample[31], s1_sample};
    endcase
    neg_nxt  = sx[32];
    av       = neg_nxt ? (~sx + 33'd1) : sx;
    a        = av[31:0];
    n        = fmt_bits(s1_fmt);
    zero_nxt = (a == 32'd0);
    ex1      = (a == {1'b0, full_scale(s1_fmt)});
    ovr      = (a == (32'd1 << n));
    // x / (2^n - 1) repeats the n-bit numerator forever; 2^n / (2^n - 1) is 1.(0..01)
    u        = ovr ? 31'd1 : a[30:0];
    rep8     = {14{u[6:0]}};
    rep16    = {7{u[14:0]}};
    rep24    = {5{u[22:0]}};
    rep32    = {4{u[30:0]}};
    unique case (s1_fmt)
      FMT_U8:  bfr = rep8[97:2];
      FMT_S16: bfr = rep16[104:9];
      FMT_S24: bfr = rep24[114:19];
      default: bfr = rep32[123:28];
    endcase
    if (ex1) bfr = 96'd0;
    s_nxt  = {(ex1 || ovr), bfr};
    lz_nxt = (ex1 || ovr) ? 6'd0 : (6'(n) - 6'(msb31(u)));
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s2_r    <= s_nxt;
      lz2_r   <= lz_nxt;
      neg2_r  <= neg_nxt;
      zero2_r <= zero_nxt;
      ex2_r   <= ex1;
    end
  end

  // Stage 3: normalize and round to 53 significant bits
  logic [96:0] nrm;
  logic [52:0] m53;
  logic        g53, stk53, rnd53;
  logic [53:0] sum53;
  logic [52:0] r53_nxt;
  logic [7:0]  e_nxt;

  logic [52:0] r53_r;
  logic [7:0]  e3_r;
  logic        neg3_r, zero3_r;

  always_comb begin
    nrm     = s2_r << lz2_r;
    m53     = nrm[96:44];
    g53     = nrm[43];
    stk53   = ~ex2_r | (|nrm[42:0]);
    rnd53   = g53 & (stk53 | m53[0]);
    sum53   = {1'b0, m53} + 54'(rnd53);
    r53_nxt = sum53[53] ? {1'b1, 52'd0} : sum53[52:0];
    e_nxt   = 8'd127 - {2'd0, lz2_r} + 8'(sum53[53]);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      r53_r   <= r53_nxt;
      e3_r    <= e_nxt;
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
    end
  end

  // Stage 4: round to 24 significant bits and pack
  logic [23:0] m24;
  logic        g24, st24, rnd24;
  logic [24:0] sum24;
  logic [7:0]  e_fin;
  logic [22:0] frac;
  logic [31:0] word_nxt;
  logic [31:0] word4_r;

  always_comb begin
    m24      = r53_r[52:29];
    g24      = r53_r[28];
    st24     = |r53_r[27:0];
    rnd24    = g24 & (st24 | m24[0]);
    sum24    = {1'b0, m24} + 25'(rnd24);
    e_fin    = e3_r + 8'(sum24[24]);
    frac     = sum24[24] ? 23'd0 : sum24[22:0];
    word_nxt = zero3_r ? 32'd0 : {neg3_r, e_fin, frac};
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      word4_r <= word_nxt;
    end
  end

  assign dec_word = word4_r;

endmodule

### hw/rtl/pcm_float_sample_converter.sv
// Top level of the PCM/float sample converter: channels, registers and pipeline control.
`timescale 1ns / 1ps
//
// Converts one audio sample per beat between float32 and packed PCM words.
// in_ch carries op (0 float32 to PCM, 1 PCM to float32) and sample_in;
// out_ch returns sample_out, one result beat per input beat, in order.
// cfg_ch writes sample_format (index 0: u8, s16, s24le, s32le) and
// big_endian_words (index 1, s16 byte swap); cfg_ch.ready is always high.
// Write configuration only while no beat is in flight.
//
// Five register stages: input capture, classify/multiply or expand,
// align or normalize/round, final rounding and pack, output register.
// After the accepting edge a beat moves through stages 2 to 4 and the output
// register to out_ch.valid; one beat per cycle is sustained while out_ch.ready
// is high, and the 24x31 multiplier stage sets the longest path.
// Reset (rst_n low, synchronous) empties the pipeline and loads s16, little
// endian. When out_ch.ready is low, beats hold in place and bubbles close up;
// in_ch.ready falls only once all five stages are full.
//
module pcm_float_sample_converter (
  input  logic           clk,
  input  logic           rst_n,
  pcf_in_if.sink         in_ch,
  pcf_out_if.source      out_ch,
  pcf_cfg_if.sink        cfg_ch
);
  import pcf_pkg::*;

  localparam int NSTG = 5;

  // Configuration registers
  logic [1:0] fmt_r;
  logic       be_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RESET;
      be_r  <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_IDX_FMT: fmt_r <= cfg_ch.data;
        CFG_IDX_BE:  be_r  <= cfg_ch.data[0];
        default:     ;
      endcase
    end
  end

  // Pipeline control: a stage takes a beat when empty or when its successor moves
  logic [NSTG-1:0] vld_r, vld_nxt, rdy, load;
  pipe_en_t        en;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    load[0] = rdy[0] && in_ch.valid;
    for (int k = 1; k < NSTG; k++) begin
      load[k] = rdy[k] && vld_r[k-1];
    end
    vld_nxt[0] = rdy[0] ? in_ch.valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
    en.s2 = load[1];
    en.s3 = load[2];
    en.s4 = load[3];
  end

  assign in_ch.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: capture the beat together with the format in force
  logic        s1_op_r, s1_be_r;
  logic [31:0] s1_sample_r;
  logic [1:0]  s1_fmt_r;
  logic        op2_r, op3_r, op4_r;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_op_r     <= in_ch.op;
      s1_sample_r <= in_ch.sample_in;
      s1_fmt_r    <= fmt_r;
      s1_be_r     <= be_r;
    end
    if (load[1]) op2_r <= s1_op_r;
    if (load[2]) op3_r <= op2_r;
    if (load[3]) op4_r <= op3_r;
  end

  // Both directions run side by side; pick one at the output register
  logic [31:0] enc_word, dec_word;

  pcf_encode u_enc (
    .clk       (clk),
    .en        (en),
    .s1_sample (s1_sample_r),
    .s1_fmt    (s1_fmt_r),
    .s1_be     (s1_be_r),
    .enc_word  (enc_word)
  );

  pcf_decode u_dec (
    .clk       (clk),
    .en        (en),
    .s1_sample (s1_sample_r),
    .s1_fmt    (s1_fmt_r),
    .s1_be     (s1_be_r),
    .dec_word  (dec_word)
  );

  logic [31:0] out_word_r;

  always_ff @(posedge clk) begin
    if (load[4]) begin
      out_word_r <= (op4_r == OP_DEC) ? dec_word : enc_word;
    end
  end

  assign out_ch.valid      = vld_r[NSTG-1];
  assign out_ch.sample_out = out_word_r;

  // An accepted beat always lands in the capture stage
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted beat did not reach stage 1");

  // Backpressure reaches the input only when every stage is occupied
  a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&vld_r))
    else $error("input stalled with a bubble in the pipeline");

  // A beat leaving the last datapath stage reaches the output register
  a_s4_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-2] && rdy[NSTG-1]) |=> vld_r[NSTG-1])
    else $error("beat lost between stage 4 and the output");

endmodule

### sim/pcf_sample_checker.sv
// Scoreboard for the PCM/float converter: tracks registers, predicts samples, compares beats.
`timescale 1ns / 1ps

module pcf_sample_checker (
  input  logic clk,
  input  logic rst_n,
  pcf_in_if    in_mon,
  pcf_out_if   out_mon,
  pcf_cfg_if   cfg_mon,
  output int   mismatches,
  output int   pending
);
  import pcf_pkg::*;

  logic [1:0]  fmt_q;
  logic        be_q;
  logic [31:0] expected_samples[$];

  // Exact value of a float32; infinities map to +/-2 since they only saturate.
  function automatic real f32_value(input logic [31:0] b);
    logic [63:0] d;
    real         r;
    if (b[30:23] == 8'hff) begin
      r = b[31] ? -2.0 : 2.0;
    end else if (b[30:23] == 8'h00) begin
      r = $itor(b[22:0]) * $bitstoreal(64'h36a0_0000_0000_0000);
      if (b[31]) r = -r;
    end else begin
      d = {b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'd0};
      r = $bitstoreal(d);
    end
    return r;
  endfunction

  // Round a nonzero double in float32 normal range to nearest even.
  function automatic logic [31:0] f32_round(input real r);
    logic [63:0] d;
    logic [30:0] body;
    logic [28:0] rem;
    if (r == 0.0) return 32'd0;
    d    = $realtobits(r);
    body = {8'(d[62:52] - 11'd896), d[51:29]};
    rem  = d[28:0];
    if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && body[0])) body = body + 31'd1;
    return {d[63], body};
  endfunction

  function automatic logic [31:0] pcm_encode(input logic [31:0] b);
    real         s;
    int          v;
    logic [15:0] w;
    if (b[30:23] == 8'hff && b[22:0] != 0) return 32'd0;
    s = f32_value(b);
    case (fmt_q)
      FMT_U8: begin
        if (s < -1.0)     return {24'd0, U8_MIN};
        else if (s > 1.0) return {24'd0, U8_MAX};
        v = $rtoi(s * 127.0 + 128.0);
        return {24'd0, v[7:0]};
      end
      FMT_S16: begin
        if (s < -1.0)     w = S16_MIN;
        else if (s > 1.0) w = S16_MAX;
        else begin
          v = $rtoi(s * 32767.0);
          w = v[15:0];
        end
        return be_q ? {16'd0, w[7:0], w[15:8]} : {16'd0, w};
      end
      FMT_S24: begin
        if (s < -1.0)     return {8'd0, S24_MIN};
        else if (s > 1.0) return {8'd0, S24_MAX};
        v = $rtoi(s * 8388607.0);
        return {8'd0, v[23:0]};
      end
      default: begin
        if (s < -1.0)     return S32_MIN;
        else if (s > 1.0) return S32_MAX;
        v = $rtoi(s * 2147483647.0);
        return v;
      end
    endcase
  endfunction

  function automatic logic [31:0] pcm_decode(input logic [31:0] word);
    logic [15:0] w;
    real         d;
    case (fmt_q)
      FMT_U8:  d = ($itor(word[7:0]) - 127.0) / 127.0;
      FMT_S16: begin
        w = be_q ? {word[7:0], word[15:8]} : word[15:0];
        d = $itor($signed(w)) / 32767.0;
      end
      FMT_S24: d = $itor($signed(word[23:0])) / 8388607.0;
      default: d = $itor($signed(word)) / 2147483647.0;
    endcase
    return f32_round(d);
  endfunction

  assign pending = expected_samples.size();

  // Sample at the falling edge: handshakes seen here complete at the next rising edge.
  always @(negedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      fmt_q = FMT_RESET;
      be_q  = 1'b0;
      mismatches = 0;
      expected_samples.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_IDX_FMT)     fmt_q = cfg_mon.data;
        else if (cfg_mon.index == CFG_IDX_BE) be_q  = cfg_mon.data[0];
      end
      if (in_mon.valid && in_mon.ready)
        expected_samples.push_back(in_mon.op == OP_DEC ? pcm_decode(in_mon.sample_in)
                                                       : pcm_encode(in_mon.sample_in));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat, expected none, actual %08h", $time,
                   out_mon.sample_out);
        end else begin
          want = expected_samples.pop_front();
          if (out_mon.sample_out !== want) begin
            mismatches++;
            $display("%0t: sample_out mismatch, expected %08h, actual %08h", $time, want,
                     out_mon.sample_out);
          end
        end
      end
    end
  end

endmodule

### sim/tb_pcm_float_sample_converter.sv
// Testbench top: clock, reset, stimulus for the PCM/float converter and the verdict.
`timescale 1ns / 1ps

module tb_pcm_float_sample_converter;
  import pcf_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches;
  int   pending;
  int   send_idle_pct = 0;   // chance per cycle that the sender stays idle
  int   recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  event hold_go;             // starts one long receiver hold-off
  logic hold_off = 1'b0;

  pcf_in_if  in_if ();
  pcf_out_if out_if ();
  pcf_cfg_if cfg_if ();

  pcm_float_sample_converter DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if), .cfg_ch(cfg_if)
  );

  pcf_sample_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_if), .out_mon(out_if), .cfg_mon(cfg_if),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold the receiver off once asked, then release it.
  always begin
    @(hold_go);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Receiver: honor a hold-off first, else stall at random.
  always @(posedge clk) begin
    if (hold_off) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one beat, idling first as the current phase asks; return at the accepting edge.
  task automatic send_beat(input logic op, input logic [31:0] sample);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= op;
    in_if.sample_in <= sample;
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Drain the pipeline, then write one register.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(negedge clk);
    while (!cfg_if.ready) @(negedge clk);
    @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly in-range floats, with edges near +/-1 and some raw bit patterns.
  function automatic logic [31:0] rand_float();
    logic [31:0] b;
    int          pick;
    b    = $urandom;
    pick = $urandom_range(9);
    if (pick == 1)      b[30:23] = 8'd127 - 8'($urandom_range(1));
    else if (pick == 2) b[30:23] = 8'($urandom_range(128, 130));
    else if (pick > 2)  b[30:23] = 8'($urandom_range(96, 126));
    return b;
  endfunction

  initial begin
    logic [31:0] directed_enc[] = '{32'h3f80_0000, 32'hbf80_0000, 32'h0000_0000, 32'h8000_0000,
                                    32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000, 32'hffff_ffff,
                                    32'h0000_0001, 32'h3f80_0001, 32'hbf80_0001, 32'h3f00_0000};
    logic [31:0] directed_dec[] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_8000, 32'h0000_7fff,
                                    32'h0080_0000, 32'h0080_0001, 32'h8000_0000, 32'h7fff_ffff,
                                    32'hffff_ff00, 32'h0000_007f, 32'h0000_0001};
    logic [1:0]  fmts[] = '{FMT_U8, FMT_S16, FMT_S16, FMT_S24, FMT_S32, FMT_S32, FMT_U8, FMT_S16};
    logic        bes[]  = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    logic        op;
    in_if.valid     <= 1'b0;
    in_if.op        <= OP_ENC;
    in_if.sample_in <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CFG_IDX_FMT;
    cfg_if.data     <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats in the reset format (s16 little endian): saturation, NaN, denormals,
    // exact +/-1, and words at the sign-bit edges of every PCM width, all read as s16.
    foreach (directed_enc[i]) send_beat(OP_ENC, directed_enc[i]);
    foreach (directed_dec[i]) send_beat(OP_DEC, directed_dec[i]);

    // Random phases, one per entry of fmts and bes, rotating the idle pattern.
    foreach (fmts[p]) begin
      write_reg(CFG_IDX_FMT, fmts[p]);
      write_reg(CFG_IDX_BE, {1'b0, bes[p]});
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int n = 0; n < 235; n++) begin
        // Fill the pipeline against a long hold-off, then let it all drain.
        if (p == 4 && n == 20) -> hold_go;
        if (p == 5 && n == 100) begin
          in_if.valid <= 1'b0;
          wait (pending == 0);
          @(posedge clk);
        end
        // Calm stretch inside each phase.
        if (n == 150) begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        op = $urandom_range(1);
        send_beat(op, op == OP_DEC ? $urandom : rand_float());
      end
    end
    in_if.valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
hw/rtl/pcf_pkg.sv
hw/rtl/pcf_ifs.sv
hw/rtl/pcf_encode.sv
hw/rtl/pcf_decode.sv
hw/rtl/pcm_float_sample_converter.sv
sim/pcf_sample_checker.sv
sim/tb_pcm_float_sample_converter.sv
